FILE: rtl/fde_pkg.sv
`default_nettype none

package fde_pkg;

  // default sizes
  localparam int MAX_DELAY_DEF   = 4096;
  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 16;

  // register and field widths
  localparam int CHAN_W     = 1;
  localparam int DELAY_W    = 12;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd2;

  // register reset values
  localparam logic [DELAY_W-1:0] DELAY_RST = 12'd1;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd0;

  // q1.15 gain arithmetic
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 16'h8000;
  localparam int                GAIN_SHIFT = 15;
  localparam int                ROUND_HALF = 16384;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic mul_fb;
    logic wr_store;
    logic mul_mix;
    logic ld_out;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/fde_ctrl.sv
`default_nettype none

module fde_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output fde_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FB   = 3'd1;
  localparam logic [2:0] S_WET  = 3'd2;
  localparam logic [2:0] S_MIX  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;
  logic       out_valid_next;

  // output register can take a new item
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // sequencing of one item
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_FB;
        end
      end
      S_FB: begin
        cmd.mul_fb = 1'b1;
        state_next = S_WET;
      end
      S_WET: begin
        cmd.wr_store = 1'b1;
        state_next   = S_MIX;
      end
      S_MIX: begin
        cmd.mul_mix = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.ld_out) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fde_dp.sv
`default_nettype none

module fde_dp #(
  parameter int MAX_DELAY   = fde_pkg::MAX_DELAY_DEF,
  parameter int CHANNELS    = fde_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = fde_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire fde_pkg::cmd_t                     cmd,
  input  wire logic                              cfg_write,
  input  wire logic [fde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fde_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [fde_pkg::CHAN_W-1:0]        channel,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample_in,
  output logic [fde_pkg::CHAN_W-1:0]             channel_out,
  output logic signed [SAMPLE_BITS-1:0]          sample_out
);

  localparam int SB     = SAMPLE_BITS;
  localparam int PW     = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NCH    = 1 << CH_W;
  localparam int AW     = CH_W + PW;
  localparam int DEPTH  = 1 << AW;
  localparam int EW     = ((PW > fde_pkg::DELAY_W) ? PW : fde_pkg::DELAY_W) + 1;
  localparam int GW     = fde_pkg::GAIN_W;
  localparam int P_W    = SB + GW + 1;
  localparam int PROD_W = SB + GW + 2;
  localparam int ACC_W  = SB + GW + 3;

  localparam logic [EW-1:0] D_MAX = EW'(MAX_DELAY - 1);
  localparam logic [PW-1:0] P_LAST = PW'(MAX_DELAY - 1);
  localparam logic [PW:0]   P_SPAN = (PW + 1)'(MAX_DELAY);
  localparam logic signed [P_W-1:0]   P_HALF   = P_W'(fde_pkg::ROUND_HALF);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(fde_pkg::ROUND_HALF);
  localparam logic signed [ACC_W-1:0] S_MAX =
    {{(ACC_W - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] S_MIN =
    {{(ACC_W - SB + 1){1'b1}}, {(SB - 1){1'b0}}};

  // saturate to the sample range
  function automatic logic signed [SB-1:0] sat(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    begin
      y = x;
      if (x > S_MAX) begin
        y = S_MAX;
      end else if (x < S_MIN) begin
        y = S_MIN;
      end
      sat = SB'(y);
    end
  endfunction

  // gains above one act as one
  function automatic logic [GW-1:0] clamp_gain(input logic [GW-1:0] g);
    begin
      clamp_gain = (g > fde_pkg::GAIN_ONE) ? fde_pkg::GAIN_ONE : g;
    end
  endfunction

  // configuration registers
  logic [fde_pkg::DELAY_W-1:0] delay_samples;
  logic [GW-1:0]               mix_gain;
  logic [GW-1:0]               feedback_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= fde_pkg::DELAY_RST;
      mix_gain      <= fde_pkg::GAIN_RST;
      feedback_gain <= fde_pkg::GAIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fde_pkg::REG_DELAY:    delay_samples <= cfg_data[fde_pkg::DELAY_W-1:0];
        fde_pkg::REG_MIX:      mix_gain      <= cfg_data[GW-1:0];
        fde_pkg::REG_FEEDBACK: feedback_gain <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  // per channel write pointers and wrap flags
  logic [PW-1:0]  wp [NCH];
  logic [NCH-1:0] wrapped;

  // item registers
  logic [CH_W-1:0]            ch_r;
  logic [fde_pkg::CHAN_W-1:0] chan_r;
  logic signed [SB-1:0]       dry_r;
  logic                       rd_ok_r;
  logic signed [SB-1:0]       rdata;
  logic signed [P_W-1:0]      p_r;
  logic signed [SB-1:0]       wet_r;
  logic signed [PROD_W-1:0]   prod_r;

  // read address from the incoming item
  logic [CH_W-1:0] ch_in;
  logic [PW-1:0]   wp_in;
  logic [EW-1:0]   d_zero;
  logic [EW-1:0]   d_eff;
  logic [PW:0]     diff;
  logic [PW-1:0]   rd;
  logic            rd_ok;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;

  always_comb begin
    ch_in  = (CHANNELS > 1) ? CH_W'(channel) : '0;
    wp_in  = wp[ch_in];
    d_zero = (delay_samples == '0) ? EW'(1) : EW'(delay_samples);
    d_eff  = (d_zero > D_MAX) ? D_MAX : d_zero;
    diff   = {1'b0, wp_in} - (PW + 1)'(d_eff);
    rd     = diff[PW] ? PW'(diff + P_SPAN) : diff[PW-1:0];
    rd_ok  = wrapped[ch_in] || (rd < wp_in);
    raddr  = {ch_in, rd};
    waddr  = {ch_r, wp[ch_r]};
  end

  // feedback product
  logic signed [SB-1:0]     delayed;
  logic signed [GW:0]       fb_s;
  logic signed [P_W-1:0]    p_next;
  logic signed [P_W-1:0]    fb_round;
  logic signed [ACC_W-1:0]  wet_sum;
  logic signed [SB-1:0]     wet;

  always_comb begin
    delayed  = rd_ok_r ? rdata : '0;
    fb_s     = $signed({1'b0, clamp_gain(feedback_gain)});
    p_next   = P_W'(delayed) * P_W'(fb_s);
    fb_round = (p_r + P_HALF) >>> fde_pkg::GAIN_SHIFT;
    wet_sum  = ACC_W'(dry_r) + ACC_W'(fb_round);
    wet      = sat(wet_sum);
  end

  // wet/dry mix as dry*one + (wet - dry)*mix
  logic signed [SB:0]        wd_diff;
  logic signed [GW:0]        mix_s;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_round;

  always_comb begin
    wd_diff   = (SB + 1)'(wet_r) - (SB + 1)'(dry_r);
    mix_s     = $signed({1'b0, clamp_gain(mix_gain)});
    prod_next = PROD_W'(wd_diff) * PROD_W'(mix_s);
    acc       = (ACC_W'(dry_r) <<< fde_pkg::GAIN_SHIFT) + ACC_W'(prod_r) + ACC_HALF;
    acc_round = acc >>> fde_pkg::GAIN_SHIFT;
  end

  // echo store, one write and one read port
  logic signed [SB-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_store) begin
      store[waddr] <= wet;
    end
    if (cmd.accept) begin
      rdata <= store[raddr];
    end
  end

  // pointer advance and wrap tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        wp[i] <= '0;
      end
      wrapped <= '0;
    end else if (cmd.wr_store) begin
      if (wp[ch_r] == P_LAST) begin
        wp[ch_r]      <= '0;
        wrapped[ch_r] <= 1'b1;
      end else begin
        wp[ch_r] <= wp[ch_r] + PW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r    <= ch_in;
      chan_r  <= channel;
      dry_r   <= sample_in;
      rd_ok_r <= rd_ok;
    end
    if (cmd.mul_fb) begin
      p_r <= p_next;
    end
    if (cmd.wr_store) begin
      wet_r <= wet;
    end
    if (cmd.mul_mix) begin
      prod_r <= prod_next;
    end
    if (cmd.ld_out) begin
      channel_out <= chan_r;
      sample_out  <= sat(acc_round);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/feedback_delay_echo.sv
// sequence: the controller walks read, feedback multiply, store write, mix multiply and
//   output load for one item at a time; the input is stalled until the result is loaded
//   into the output register, which waits while a stalled result is still held there
// reset: pointers, wrap flags, configuration registers and handshake state clear;
//   the echo store itself is not swept, entries not yet written read as zero
`default_nettype none

module feedback_delay_echo #(
  parameter int MAX_DELAY   = fde_pkg::MAX_DELAY_DEF,
  parameter int CHANNELS    = fde_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = fde_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [fde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fde_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [fde_pkg::CHAN_W-1:0]        channel,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [fde_pkg::CHAN_W-1:0]             channel_out,
  output logic signed [SAMPLE_BITS-1:0]          sample_out
);

  fde_pkg::cmd_t cmd;

  // sequencer
  fde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // store and arithmetic
  fde_dp #(
    .MAX_DELAY   (MAX_DELAY),
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .channel     (channel),
    .sample_in   (sample_in),
    .channel_out (channel_out),
    .sample_out  (sample_out)
  );

  // an accepted item blocks the input until it is finished
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after an item");

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    cmd.ld_out |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled item");

  // the store write follows the feedback multiply of the same item
  assert property (@(posedge clk) disable iff (rst)
    cmd.wr_store |-> $past(cmd.mul_fb))
    else $error("store write out of sequence");

  // one result per item: the input is still stalled in the output state after the mix multiply
  assert property (@(posedge clk) disable iff (rst)
    cmd.wr_store |=> ##1 (in_stall && !cmd.accept))
    else $error("item left before its result was formed");

endmodule

`default_nettype wire

FILE: dv/feedback_delay_echo_tb.sv
`default_nettype none

module feedback_delay_echo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fde_pkg::*;

  localparam int SB    = SAMPLE_BITS_DEF;
  localparam int DEPTH = MAX_DELAY_DEF;
  localparam int CHANS = CHANNELS_DEF;

  // index past the last register, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam longint SAMPLE_HI = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

  typedef logic signed [SB-1:0] sample_t;

  typedef struct {
    logic [CHAN_W-1:0] ch;
    sample_t           smp;
  } echo_out_t;

  // dut ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CHAN_W-1:0]     channel = '0;
  sample_t               sample_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAN_W-1:0]     channel_out;
  sample_t               sample_out;

  // predictor state
  sample_t            echo_mem [CHANS][DEPTH];
  int unsigned        wr_ptr [CHANS];
  logic [DELAY_W-1:0] delay_reg;
  logic [GAIN_W-1:0]  mix_reg;
  logic [GAIN_W-1:0]  fb_reg;

  echo_out_t echo_due[$];
  int        fail_count = 0;
  bit        no_idle = 1'b0;

  feedback_delay_echo dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .channel    (channel),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .channel_out(channel_out),
    .sample_out (sample_out)
  );

  always #5 clk = ~clk;

  // q1.15 rounding, half up with a floor shift
  function automatic longint round_q15(input longint x);
    return (x + ROUND_HALF) >>> GAIN_SHIFT;
  endfunction

  function automatic longint clip_sample(input longint x);
    if (x > SAMPLE_HI) return SAMPLE_HI;
    if (x < SAMPLE_LO) return SAMPLE_LO;
    return x;
  endfunction

  function automatic longint clamp_gain(input logic [GAIN_W-1:0] g);
    return (g > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(g);
  endfunction

  // echo predictor: read the tap, feed back, store wet, mix with dry
  function automatic echo_out_t echo_predict(input logic [CHAN_W-1:0] ch, input sample_t dry);
    int unsigned d, rd, wp, slot;
    longint      tap, wet, acc, fb, mx, dry_l;
    echo_out_t   res;
    slot = ch % CHANS;
    d = delay_reg;
    if (d == 0) d = 1;
    if (d > DEPTH - 1) d = DEPTH - 1;
    wp = wr_ptr[slot] % DEPTH;
    rd = (wp + DEPTH - d) % DEPTH;
    fb = clamp_gain(fb_reg);
    mx = clamp_gain(mix_reg);
    dry_l = longint'(dry);
    tap = longint'(echo_mem[slot][rd]);
    wet = clip_sample(dry_l + round_q15(tap * fb));
    echo_mem[slot][wp] = sample_t'(wet);
    wr_ptr[slot] = (wp + 1) % DEPTH;
    acc = wet * mx + dry_l * (longint'(GAIN_ONE) - mx);
    res.ch = ch;
    res.smp = sample_t'(clip_sample(round_q15(acc)));
    return res;
  endfunction

  // register write, predictor follows at the write edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_DELAY:    delay_reg = val[DELAY_W-1:0];
      REG_MIX:      mix_reg   = val[GAIN_W-1:0];
      REG_FEEDBACK: fb_reg    = val[GAIN_W-1:0];
      default:      ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_echo(input logic [CFG_DATA_W-1:0] dly, input logic [CFG_DATA_W-1:0] mx,
                          input logic [CFG_DATA_W-1:0] fb);
    write_reg(REG_DELAY, dly);
    write_reg(REG_MIX, mx);
    write_reg(REG_FEEDBACK, fb);
  endtask

  // send one item, with random idle cycles ahead of it
  task automatic send_sample(input logic [CHAN_W-1:0] ch, input sample_t smp);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    channel   <= ch;
    sample_in <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    echo_due.push_back(echo_predict(ch, smp));
  endtask

  // hold off the sender until every expected result is back
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (echo_due.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (echo_due.size() != 0) begin
      $display("%0t: %0d results missing", $time, echo_due.size());
      fail_count += echo_due.size();
      echo_due.delete();
    end
    repeat (10) @(posedge clk);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0:       return sample_t'(SAMPLE_HI);
      1:       return sample_t'(SAMPLE_LO);
      2:       return sample_t'($urandom_range(64)) - sample_t'(32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    case ($urandom_range(7))
      0:       return '0;
      1:       return GAIN_ONE;
      2:       return CFG_DATA_W'($urandom_range(65535, 32769));
      default: return CFG_DATA_W'($urandom_range(32768));
    endcase
  endfunction

  // mostly short delays so echoes come back within the run
  function automatic logic [CFG_DATA_W-1:0] rand_delay();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'(DEPTH - 1);
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(40, 1));
    endcase
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 17);
  end

  // result checker
  always @(posedge clk) begin
    echo_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (echo_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result channel %0d sample %0d", $time, channel_out,
                 sample_out);
      end else begin
        want = echo_due.pop_front();
        if (channel_out !== want.ch) begin
          fail_count++;
          $display("%0t: channel_out expected %0d actual %0d", $time, want.ch, channel_out);
        end
        if (sample_out !== want.smp) begin
          fail_count++;
          $display("%0t: sample_out expected %0d actual %0d", $time, want.smp, sample_out);
        end
      end
    end
  end

  // reset settings: mix of zero passes the dry sample through
  task automatic test_reset_settings();
    send_sample(1'b0, sample_t'(SAMPLE_HI));
    send_sample(1'b1, sample_t'(SAMPLE_LO));
    send_sample(1'b0, sample_t'(-1));
    send_sample(1'b1, sample_t'(0));
    wait_drained();
  endtask

  // full gains, zero delay, saturation of wet and output
  task automatic test_full_gain_zero_delay();
    set_echo(16'd0, GAIN_ONE, GAIN_ONE);
    send_sample(1'b0, sample_t'(SAMPLE_HI));
    send_sample(1'b0, sample_t'(SAMPLE_HI));
    send_sample(1'b0, sample_t'(SAMPLE_HI));
    send_sample(1'b1, sample_t'(SAMPLE_LO));
    send_sample(1'b1, sample_t'(SAMPLE_LO));
    send_sample(1'b0, sample_t'(SAMPLE_LO));
    send_sample(1'b1, sample_t'(12345));
    wait_drained();
  endtask

  // gains above one, longest delay, high data bits and an unused index
  task automatic test_register_edges();
    set_echo(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(1'b0, sample_t'(20000));
    send_sample(1'b1, sample_t'(-20000));
    wait_drained();
    write_reg(REG_DELAY, 16'hF002);
    write_reg(REG_MIX, 16'd16384);
    write_reg(REG_FEEDBACK, 16'd16385);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_sample(1'b0, sample_t'(1));
    send_sample(1'b0, sample_t'(-1));
    send_sample(1'b0, sample_t'(SAMPLE_HI));
    send_sample(1'b0, sample_t'(SAMPLE_LO));
    send_sample(1'b1, sample_t'(16384));
    send_sample(1'b1, sample_t'(-16385));
    wait_drained();
  endtask

  // random settings per phase, random items within
  task automatic test_random_phases();
    int n;
    for (int ph = 0; ph < 6; ph++) begin
      set_echo(rand_delay(), rand_gain(), rand_gain());
      n = $urandom_range(70, 30);
      for (int i = 0; i < n; i++) begin
        send_sample(CHAN_W'($urandom_range(1)), rand_sample());
      end
      wait_drained();
    end
  endtask

  // long run with no idling on either side
  task automatic test_back_to_back();
    set_echo(16'd7, 16'd24576, 16'd26000);
    no_idle = 1'b1;
    for (int i = 0; i < 120; i++) begin
      send_sample(CHAN_W'($urandom_range(1)), rand_sample());
    end
    wait_drained();
    no_idle = 1'b0;
  endtask

  // stimulus sequence
  initial begin
    foreach (echo_mem[c, a]) echo_mem[c][a] = '0;
    foreach (wr_ptr[c]) wr_ptr[c] = 0;
    delay_reg = DELAY_RST;
    mix_reg   = GAIN_RST;
    fb_reg    = GAIN_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_full_gain_zero_delay();
    test_register_edges();
    test_random_phases();
    test_back_to_back();
    test_random_phases();
    wait_drained();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
